FILE: rtl/sbt_pkg.sv
// Shared constants, codes and types for the smoke background tracker.
`default_nettype none

package sbt_pkg;

  // Fixed field widths
  localparam int LVL_W   = 10;
  localparam int ALARM_W = 10;
  localparam int READ_W  = 7;
  localparam int TICK_W  = 9;

  // Tracking period in ticks and the number of level bits honoured
  localparam int UPDATE_PERIOD = 450;
  localparam int LEVEL_BITS    = 10;

  localparam int HIST_DEPTH = 6;

  // Serial divider sizing: dividend up to 1023*32 + 1023*23 fits 16 bits
  localparam int DIV_W = 16;
  localparam int CNT_W = 4;

  // Legal windows and defaults
  localparam logic [ALARM_W-1:0] ALARM_MIN     = 10'd20;
  localparam logic [ALARM_W-1:0] ALARM_MAX     = 10'd600;
  localparam logic [ALARM_W-1:0] ALARM_DEFAULT = 10'd30;
  localparam logic [LVL_W-1:0]   BG_MIN        = 10'd20;
  localparam logic [LVL_W-1:0]   BG_MAX        = 10'd500;
  localparam logic [LVL_W-1:0]   BG_DEFAULT    = 10'd60;
  localparam logic [LVL_W-1:0]   DRIFT_LIMIT   = 10'd800;

  localparam logic [7:0] ALARM_MULT = 8'd23;

  // Reading limits
  localparam logic [READ_W-1:0] READ_MIN    = 7'd9;
  localparam logic [READ_W-1:0] READ_MAX    = 7'd99;
  localparam logic [READ_W-1:0] FAULT_LIMIT = 7'd54;

  // Fault codes
  localparam logic [READ_W-1:0] CODE_SENSOR = 7'h01;
  localparam logic [READ_W-1:0] CODE_DRIFT  = 7'h02;
  localparam logic [READ_W-1:0] CODE_CONFIG = 7'h04;
  localparam logic [READ_W-1:0] CODE_STORE  = 7'h08;

  typedef enum logic {
    OP_INIT = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic {
    REG_ALARM_LEVEL = 1'b0,
    REG_INITIAL_BG  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/smoke_background_tracker.sv
// Top level of the smoke background tracker: sequencer, state and serial divider.
`default_nettype none

// Each accepted word (init or tick) yields exactly one result word. The
// block handles one word at a time: accept, apply init or tick/tracking
// state changes, form the dividend, run a shared restoring divider (one
// quotient bit a cycle), then form the reading and load the output
// register. A new word is taken only once the last one has been loaded
// into the output register. The output register holds a finished word
// while the input side already takes the next one; in_stall is high while
// a word is being worked on, or while the finished word waits for a full
// output register to drain. Configuration registers are read only by an
// init word; write them only while the block is idle. Level bits above
// LEVEL_BITS are ignored.
module smoke_background_tracker (
  input  wire                            clk,
  input  wire                            rst_n,
  // configuration write port
  input  wire                            cfg_we,
  input  wire                            cfg_index,
  input  wire [sbt_pkg::ALARM_W-1:0]     cfg_data,
  // input channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_op,
  input  wire [sbt_pkg::LVL_W-1:0]       in_level,
  input  wire                            in_sensor_fault,
  input  wire                            in_store_fault,
  input  wire                            in_other_fault,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [sbt_pkg::READ_W-1:0]     out_reading,
  output logic [sbt_pkg::LVL_W-1:0]      out_background,
  output logic                           out_drift_flag,
  output logic                           out_config_fault
);

  localparam int LVL_W   = sbt_pkg::LVL_W;
  localparam int ALARM_W = sbt_pkg::ALARM_W;
  localparam int READ_W  = sbt_pkg::READ_W;
  localparam int TICK_W  = sbt_pkg::TICK_W;
  localparam int DIV_W   = sbt_pkg::DIV_W;
  localparam int CNT_W   = sbt_pkg::CNT_W;
  localparam int HIST_D  = sbt_pkg::HIST_DEPTH;

  localparam logic [LVL_W-1:0]  LEVEL_MASK = LVL_W'((1 << sbt_pkg::LEVEL_BITS) - 1);
  localparam logic [TICK_W-1:0] PERIOD     = TICK_W'(sbt_pkg::UPDATE_PERIOD);
  localparam logic [CNT_W-1:0]  LAST_STEP  = CNT_W'(DIV_W - 1);

  // Configuration registers
  logic [ALARM_W-1:0] cfg_alarm_r;
  logic [LVL_W-1:0]   cfg_bg_r;

  // Tracker state
  logic [LVL_W-1:0]   bg_r;
  logic [ALARM_W-1:0] alarm_r;
  logic [LVL_W-1:0]   recent_r;
  logic [LVL_W-1:0]   hist_r [HIST_D];
  logic [TICK_W-1:0]  tick_r;
  logic               parity_r;
  logic               drift_r;
  logic               cfg_bad_r;

  // Captured input word
  logic               op_r;
  logic [LVL_W-1:0]   lvl_r;
  logic               sensor_r;
  logic               store_r;
  logic               other_r;

  // Divider
  logic [DIV_W-1:0]   dvd_r;
  logic [ALARM_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               pos_r;

  // Output register
  logic               out_valid_r;
  logic [READ_W-1:0]  out_reading_r;
  logic [LVL_W-1:0]   out_bg_r;
  logic               out_drift_r;
  logic               out_cfg_r;

  sbt_pkg::state_t    state_r, state_nxt;

  // Sequencer decodes
  logic in_take;
  logic do_update;
  logic do_prep;
  logic do_div;
  logic do_load;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbt_pkg::ST_IDLE:   if (in_valid) state_nxt = sbt_pkg::ST_UPDATE;
      sbt_pkg::ST_UPDATE: state_nxt = sbt_pkg::ST_PREP;
      sbt_pkg::ST_PREP:   state_nxt = sbt_pkg::ST_DIV;
      sbt_pkg::ST_DIV:    if (cnt_r == LAST_STEP) state_nxt = sbt_pkg::ST_DONE;
      sbt_pkg::ST_DONE:   if (out_free) state_nxt = sbt_pkg::ST_IDLE;
      default:            state_nxt = sbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    do_update = 1'b0;
    do_prep   = 1'b0;
    do_div    = 1'b0;
    do_load   = 1'b0;
    unique case (state_r)
      sbt_pkg::ST_IDLE:   in_stall  = 1'b0;
      sbt_pkg::ST_UPDATE: do_update = 1'b1;
      sbt_pkg::ST_PREP:   do_prep   = 1'b1;
      sbt_pkg::ST_DIV:    do_div    = 1'b1;
      sbt_pkg::ST_DONE:   do_load   = out_free;
      default:            in_stall  = 1'b1;
    endcase
  end

  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_alarm_r <= sbt_pkg::ALARM_DEFAULT;
      cfg_bg_r    <= sbt_pkg::BG_DEFAULT;
    end else if (cfg_we) begin
      unique case (sbt_pkg::reg_idx_t'(cfg_index))
        sbt_pkg::REG_ALARM_LEVEL: cfg_alarm_r <= cfg_data;
        sbt_pkg::REG_INITIAL_BG:  cfg_bg_r    <= cfg_data;
        default:                  cfg_alarm_r <= cfg_alarm_r;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= in_op;
      lvl_r    <= in_level & LEVEL_MASK;
      sensor_r <= in_sensor_fault;
      store_r  <= in_store_fault;
      other_r  <= in_other_fault;
    end
  end

  // Init checks
  logic               bg_bad;
  logic               alarm_bad;
  logic [LVL_W-1:0]   bg_init;
  logic [ALARM_W-1:0] alarm_init;

  assign bg_bad     = (cfg_bg_r > sbt_pkg::BG_MAX) || (cfg_bg_r < sbt_pkg::BG_MIN);
  assign alarm_bad  = (cfg_alarm_r > sbt_pkg::ALARM_MAX) || (cfg_alarm_r < sbt_pkg::ALARM_MIN);
  assign bg_init    = bg_bad ? sbt_pkg::BG_DEFAULT : cfg_bg_r;
  assign alarm_init = alarm_bad ? sbt_pkg::ALARM_DEFAULT : cfg_alarm_r;

  // Tick and tracking decisions
  logic [TICK_W-1:0]  tick_inc;
  logic               period_hit;
  logic               parity_new;
  logic [ALARM_W-1:0] half, quarter, eighth;
  logic [LVL_W-1:0]   diff_recent, diff_new, diff_old;
  logic               check_old;
  logic               bg_accept;

  function automatic logic [LVL_W-1:0] abs_diff(input logic [LVL_W-1:0] a,
                                                 input logic [LVL_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  assign tick_inc    = tick_r + TICK_W'(1);
  assign period_hit  = tick_inc >= PERIOD;
  assign parity_new  = ~parity_r;
  assign half        = alarm_r >> 1;
  assign quarter     = alarm_r >> 2;
  assign eighth      = alarm_r >> 3;
  assign diff_recent = abs_diff(lvl_r, recent_r);
  assign diff_new    = abs_diff(lvl_r, hist_r[0]);
  assign diff_old    = abs_diff(lvl_r, hist_r[HIST_D-1]);
  assign check_old   = (eighth > diff_recent) || !(quarter < diff_new);
  assign bg_accept   = check_old && !(half < diff_old);

  // Tracker state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r      <= sbt_pkg::BG_DEFAULT;
      alarm_r   <= sbt_pkg::ALARM_DEFAULT;
      recent_r  <= sbt_pkg::BG_DEFAULT;
      for (int i = 0; i < HIST_D; i++) begin
        hist_r[i] <= sbt_pkg::BG_DEFAULT;
      end
      tick_r    <= '0;
      parity_r  <= 1'b0;
      drift_r   <= 1'b0;
      cfg_bad_r <= 1'b0;
    end else if (do_update) begin
      if (sbt_pkg::op_t'(op_r) == sbt_pkg::OP_INIT) begin
        // Seed background and history from the checked registers
        if (bg_bad || alarm_bad) begin
          cfg_bad_r <= 1'b1;
        end
        bg_r     <= bg_init;
        alarm_r  <= alarm_init;
        recent_r <= bg_init;
        for (int i = 0; i < HIST_D; i++) begin
          hist_r[i] <= bg_init;
        end
      end else if (period_hit) begin
        tick_r   <= '0;
        parity_r <= parity_new;
        if (bg_accept) begin
          bg_r    <= lvl_r;
          drift_r <= lvl_r > sbt_pkg::DRIFT_LIMIT;
        end
        // Deep history advances on alternate updates only
        if (!parity_new) begin
          for (int i = 1; i < HIST_D; i++) begin
            hist_r[i] <= hist_r[i-1];
          end
        end
        hist_r[0] <= recent_r;
        recent_r  <= lvl_r;
      end else begin
        tick_r <= tick_inc;
      end
    end
  end

  // Dividend: level*32 + alarm*23 - background*32
  logic [DIV_W-1:0]   num;
  logic [DIV_W-1:0]   base;
  logic [LVL_W:0]     trial;
  logic               trial_ge;

  assign num  = DIV_W'({lvl_r, 5'b0}) + DIV_W'(alarm_r * sbt_pkg::ALARM_MULT);
  assign base = DIV_W'({bg_r, 5'b0});

  // Shared restoring step: one quotient bit a cycle
  assign trial    = {rem_r, dvd_r[DIV_W-1]};
  assign trial_ge = trial >= {1'b0, alarm_r};

  always_ff @(posedge clk) begin
    if (do_prep) begin
      pos_r <= num > base;
      dvd_r <= num - base;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (do_div) begin
      rem_r <= trial_ge ? ALARM_W'(trial - {1'b0, alarm_r}) : ALARM_W'(trial);
      dvd_r <= {dvd_r[DIV_W-2:0], trial_ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Clamp the quotient and substitute a fault code where needed
  logic [READ_W-1:0] conc;
  logic              any_fault;
  logic [READ_W-1:0] code;
  logic [READ_W-1:0] reading;

  always_comb begin
    if (!pos_r) begin
      conc = sbt_pkg::READ_MIN;
    end else if (dvd_r > DIV_W'(sbt_pkg::READ_MAX)) begin
      conc = sbt_pkg::READ_MAX;
    end else if (dvd_r < DIV_W'(sbt_pkg::READ_MIN)) begin
      conc = sbt_pkg::READ_MIN;
    end else begin
      conc = dvd_r[READ_W-1:0];
    end
  end

  assign any_fault = sensor_r || store_r || other_r || drift_r || cfg_bad_r;

  always_comb begin
    code = '0;
    if (sensor_r) code = code | sbt_pkg::CODE_SENSOR;
    if (drift_r)  code = code | sbt_pkg::CODE_DRIFT;
    if (cfg_bad_r) code = sbt_pkg::CODE_CONFIG;
    if (store_r)  code = sbt_pkg::CODE_STORE;
  end

  assign reading = (any_fault && (conc < sbt_pkg::FAULT_LIMIT)) ? code : conc;

  // Output register: hold until taken, reload as it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      out_reading_r <= reading;
      out_bg_r      <= bg_r;
      out_drift_r   <= drift_r;
      out_cfg_r     <= cfg_bad_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reading      = out_reading_r;
  assign out_background   = out_bg_r;
  assign out_drift_flag   = out_drift_r;
  assign out_config_fault = out_cfg_r;

endmodule

`default_nettype wire

FILE: dv/tb_smoke_background_tracker.sv
// Self-checking testbench for the smoke background tracker: directed table, then random phases.
module tb_smoke_background_tracker;
  import sbt_pkg::*;

  localparam int CLK_PERIOD = 20;
  // Slowest legal run is roughly 1.2k words; the limit leaves ample margin.
  localparam int LIMIT_CYCLES = 1_000_000;

  // One input word and one result word, as the ports carry them
  typedef struct packed {
    op_t              op;
    logic [LVL_W-1:0] level;
    logic             sensor;
    logic             store;
    logic             other;
  } tracker_word_t;

  typedef struct packed {
    logic [READ_W-1:0] reading;
    logic [LVL_W-1:0]  background;
    logic              drift;
    logic              cfg_fault;
  } reading_t;

  // A row of the directed table; pinned rows carry a hand-worked reading
  typedef struct {
    tracker_word_t w;
    bit            pinned;
    reading_t      r;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  reg_idx_t               cfg_index = REG_ALARM_LEVEL;
  logic [ALARM_W-1:0]     cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  op_t                    in_op = OP_TICK;
  logic [LVL_W-1:0]       in_level = '0;
  logic                   in_sensor_fault = 1'b0;
  logic                   in_store_fault = 1'b0;
  logic                   in_other_fault = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [READ_W-1:0]      out_reading;
  logic [LVL_W-1:0]       out_background;
  logic                   out_drift_flag;
  logic                   out_config_fault;

  smoke_background_tracker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_level         (in_level),
    .in_sensor_fault  (in_sensor_fault),
    .in_store_fault   (in_store_fault),
    .in_other_fault   (in_other_fault),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reading      (out_reading),
    .out_background   (out_background),
    .out_drift_flag   (out_drift_flag),
    .out_config_fault (out_config_fault)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracker state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [ALARM_W-1:0] alarm_reg = ALARM_DEFAULT;   // register copies
  logic [LVL_W-1:0]   bg_reg = BG_DEFAULT;
  logic [LVL_W-1:0]   bg_now = BG_DEFAULT;
  logic [ALARM_W-1:0] alarm_now = ALARM_DEFAULT;
  logic [LVL_W-1:0]   recent_lvl = BG_DEFAULT;
  logic [LVL_W-1:0]   lvl_hist [HIST_DEPTH];
  logic [TICK_W-1:0]  tick_cnt = '0;
  logic               shift_parity = 1'b0;
  logic               drift_on = 1'b0;
  logic               cfg_latched = 1'b0;
  int                 track_total = 0;

  reading_t           reading_fifo [$];   // readings still owed by the block
  int                 mismatches = 0;
  int                 results_seen = 0;
  int                 burst_left = 1;

  initial begin
    foreach (lvl_hist[i]) lvl_hist[i] = BG_DEFAULT;
  end

  function automatic int level_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [LVL_W-1:0] fit_level(input int v);
    if (v < 0) return '0;
    if (v > 1023) return 10'd1023;
    return v[LVL_W-1:0];
  endfunction

  // Advance the tracker by one word and work out the reading it produces
  function automatic reading_t tracker_step(input tracker_word_t w);
    reading_t         r;
    int               lvl, n, b, c, half, quarter, eighth;
    logic [LVL_W-1:0] bg;
    logic [ALARM_W-1:0] al;
    bit               check_old, take;
    lvl = w.level;
    if (w.op == OP_INIT) begin
      // Replace an out-of-window value by its default and latch the fault
      bg = bg_reg;
      al = alarm_reg;
      if (bg > BG_MAX || bg < BG_MIN) begin
        cfg_latched = 1'b1;
        bg = BG_DEFAULT;
      end
      if (al > ALARM_MAX || al < ALARM_MIN) begin
        cfg_latched = 1'b1;
        al = ALARM_DEFAULT;
      end
      bg_now = bg;
      alarm_now = al;
      recent_lvl = bg;
      foreach (lvl_hist[i]) lvl_hist[i] = bg;
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= UPDATE_PERIOD) begin
        tick_cnt = '0;
        shift_parity = ~shift_parity;
        track_total++;
        half = alarm_now >> 1;
        quarter = half >> 1;
        eighth = quarter >> 1;
        check_old = (eighth > level_gap(lvl, recent_lvl)) ||
                    !(quarter < level_gap(lvl, lvl_hist[0]));
        take = check_old && !(half < level_gap(lvl, lvl_hist[HIST_DEPTH-1]));
        if (take) begin
          bg_now = lvl[LVL_W-1:0];
          drift_on = (lvl > DRIFT_LIMIT);
        end
        // the deep history only moves on alternate updates
        if (!shift_parity) begin
          for (int i = HIST_DEPTH - 1; i > 0; i--) lvl_hist[i] = lvl_hist[i-1];
        end
        lvl_hist[0] = recent_lvl;
        recent_lvl = lvl[LVL_W-1:0];
      end
    end

    n = lvl * 32 + alarm_now * ALARM_MULT;
    b = bg_now * 32;
    if (n > b) begin
      c = (alarm_now != 0) ? (n - b) / alarm_now : READ_MAX;
      if (c < READ_MIN) c = READ_MIN;
      if (c > READ_MAX) c = READ_MAX;
    end else begin
      c = READ_MIN;
    end
    if ((w.sensor || w.store || w.other || drift_on || cfg_latched) && c < FAULT_LIMIT) begin
      n = 0;
      if (w.sensor) n = n | CODE_SENSOR;
      if (drift_on) n = n | CODE_DRIFT;
      if (cfg_latched) n = CODE_CONFIG;
      if (w.store) n = CODE_STORE;
      c = n;
    end
    r.reading = c[READ_W-1:0];
    r.background = bg_now;
    r.drift = drift_on;
    r.cfg_fault = cfg_latched;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [LVL_W-1:0] near_level(input int base, input int d);
    return fit_level(base - d + $urandom_range(0, 2 * d));
  endfunction

  // Choose the next word; a tick that will run tracking gets a level near
  // the history so that acceptance and rejection both happen. In climb mode
  // the tracking levels walk upwards to drag the background past the drift limit.
  function automatic tracker_word_t pick_word(input bit allow_init, input bit climb);
    tracker_word_t w;
    int            sel, span;
    w.sensor = ($urandom_range(0, 3) == 0);
    w.store  = ($urandom_range(0, 3) == 0);
    w.other  = ($urandom_range(0, 3) == 0);
    w.op = (allow_init && $urandom_range(0, 19) == 0) ? OP_INIT : OP_TICK;
    span = alarm_now;
    sel = $urandom_range(0, 9);
    if (w.op == OP_TICK && tick_cnt == UPDATE_PERIOD - 1) begin
      if (climb) begin
        if (sel < 7) w.level = fit_level(recent_lvl + $urandom_range(30, 100));
        else if (sel < 9) w.level = near_level(recent_lvl, 10);
        else w.level = LVL_W'($urandom_range(0, 1023));
        if (w.level > 900) w.level = 10'd900;
      end else begin
        if (sel < 3) w.level = near_level(recent_lvl, span / 4);
        else if (sel < 6) w.level = near_level(lvl_hist[0], span / 2);
        else if (sel < 8) w.level = near_level(lvl_hist[HIST_DEPTH-1], span);
        else w.level = LVL_W'($urandom_range(0, 1023));
      end
    end else begin
      if (sel == 0) begin
        case ($urandom_range(0, 2))
          0: w.level = '0;
          1: w.level = 10'd1023;
          default: w.level = LVL_W'($urandom_range(0, 1023));
        endcase
      end else if (sel < 6) begin
        // near the background the reading sweeps the whole 9..99 range
        w.level = fit_level(bg_now - span + $urandom_range(0, 4 * span));
      end else begin
        w.level = LVL_W'($urandom_range(0, 1023));
      end
    end
    return w;
  endfunction

  // Offer one word, hold it until accepted, then book its reading.
  // Bursts of back-to-back words are separated by random gaps.
  task automatic send_word(input tracker_word_t w, input bit pinned, input reading_t pin_r);
    reading_t r;
    int       gap;
    in_valid        <= 1'b1;
    in_op           <= w.op;
    in_level        <= w.level;
    in_sensor_fault <= w.sensor;
    in_store_fault  <= w.store;
    in_other_fault  <= w.other;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = tracker_step(w);
    reading_fifo.push_back(pinned ? pin_r : r);
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 2) == 0) gap = 0;
      else if ($urandom_range(0, 15) == 0) gap = 60;
      else gap = $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Drop valid and wait until every owed reading has come back
  task automatic drain_words();
    if (in_valid) in_valid <= 1'b0;
    while (reading_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers; only called with the block idle
  task automatic load_settings(input logic [ALARM_W-1:0] al, input logic [LVL_W-1:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ALARM_LEVEL;
    cfg_data  <= al;
    @(posedge clk);
    cfg_index <= REG_INITIAL_BG;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_we <= 1'b0;
    alarm_reg = al;
    bg_reg = bg;
    @(posedge clk);
  endtask

  // One setting: load it, init from it, then random words. A climb phase
  // runs ticks only until at least 16 updates passed and the background drifted, or 30 passed.
  task automatic run_phase(input logic [ALARM_W-1:0] al, input logic [LVL_W-1:0] bg,
                           input int count, input bit climb);
    tracker_word_t w;
    int            sent, t0;
    load_settings(al, bg);
    w = pick_word(1'b0, 1'b0);
    w.op = OP_INIT;
    send_word(w, 1'b0, '0);
    sent = 1;
    t0 = track_total;
    while (climb ? !((track_total - t0 >= 16 && drift_on) || track_total - t0 >= 30)
                 : sent < count) begin
      send_word(pick_word(!climb, climb), 1'b0, '0);
      sent++;
    end
    drain_words();
  endtask

  function automatic dir_row_t mk_row(input op_t op, input int lvl, input bit s, input bit st,
                                      input bit ot, input bit pinned, input int rd,
                                      input int bg);
    dir_row_t row;
    row.w.op = op;
    row.w.level = lvl[LVL_W-1:0];
    row.w.sensor = s;
    row.w.store = st;
    row.w.other = ot;
    row.pinned = pinned;
    row.r.reading = rd[READ_W-1:0];
    row.r.background = bg[LVL_W-1:0];
    row.r.drift = 1'b0;
    row.r.cfg_fault = 1'b0;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and stall pattern
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch on result %0d: %0s got %0d, want %0d", results_seen, what, got, want);
  endtask

  reading_t rx_want;
  int       stall_mode = 0;
  int       stall_left = 0;
  int       stall_phase = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reading_fifo.size() == 0) begin
        flag_mismatch("unrequested result, reading", out_reading, 0);
      end else begin
        rx_want = reading_fifo.pop_front();
        if (out_reading !== rx_want.reading)
          flag_mismatch("reading", out_reading, rx_want.reading);
        if (out_background !== rx_want.background)
          flag_mismatch("background", out_background, rx_want.background);
        if (out_drift_flag !== rx_want.drift)
          flag_mismatch("drift_flag", out_drift_flag, rx_want.drift);
        if (out_config_fault !== rx_want.cfg_fault)
          flag_mismatch("config_fault", out_config_fault, rx_want.cfg_fault);
      end
      results_seen++;
    end
    // change stall mode now and then: none, light, heavy, fixed 5-of-8
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 400);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_phase % 8) < 5);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [$];

  initial begin
    logic [ALARM_W-1:0] al;
    logic [LVL_W-1:0]   bg;
    // Directed rows from reset: alarm 30, background 60, no faults latched
    dir_tab.push_back(mk_row(OP_TICK, 0,    0, 0, 0, 1, READ_MIN,    BG_DEFAULT));
    dir_tab.push_back(mk_row(OP_TICK, 1023, 0, 0, 0, 1, READ_MAX,    BG_DEFAULT));
    dir_tab.push_back(mk_row(OP_TICK, 0,    1, 0, 0, 1, CODE_SENSOR, BG_DEFAULT));
    dir_tab.push_back(mk_row(OP_TICK, 0,    0, 1, 0, 1, CODE_STORE,  BG_DEFAULT));
    // only the further fault bit: code stays zero
    dir_tab.push_back(mk_row(OP_TICK, 0,    0, 0, 1, 1, 0,           BG_DEFAULT));
    dir_tab.push_back(mk_row(OP_TICK, 0,    1, 1, 1, 1, CODE_STORE,  BG_DEFAULT));
    // a high reading hides every fault
    dir_tab.push_back(mk_row(OP_TICK, 1023, 1, 1, 1, 1, READ_MAX,    BG_DEFAULT));
    // init words give a reading too, from the freshly seeded state
    dir_tab.push_back(mk_row(OP_INIT, 0,    0, 0, 0, 1, READ_MIN,    BG_DEFAULT));
    dir_tab.push_back(mk_row(OP_INIT, 1023, 0, 0, 0, 1, READ_MAX,    BG_DEFAULT));
    // either side of the fault threshold
    dir_tab.push_back(mk_row(OP_TICK, 89,   1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK, 90,   1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK, 60,   0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK, 61,   1, 0, 1, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK, 512,  0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK, 511,  0, 1, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK, 85,   0, 0, 1, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_INIT, 70,   1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK, 341,  0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK, 682,  1, 0, 0, 0, 0, 0));

    // Hold reset, then release it and let the block settle before the first word
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = $urandom_range(1, 12);

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].pinned, dir_tab[i].r);
    drain_words();

    // Legal settings first: the config fault is sticky until reset
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin al = ALARM_DEFAULT; bg = BG_DEFAULT; end
        1: begin al = ALARM_MAX;     bg = BG_MAX;     end
        2: begin al = ALARM_MIN;     bg = BG_MIN;     end
        3: begin al = ALARM_MAX;     bg = BG_MIN;     end
        4: begin al = ALARM_MIN;     bg = BG_MAX;     end
        default: begin
          al = ALARM_W'($urandom_range(ALARM_MIN, ALARM_MAX));
          bg = LVL_W'($urandom_range(BG_MIN, BG_MAX));
        end
      endcase
      run_phase(al, bg, 140, 1'b0);
    end

    // Out-of-window settings: defaults take over and the fault latches
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin al = 10'd0;    bg = 10'd0;    end
        1: begin al = 10'd1023; bg = 10'd1023; end
        2: begin al = ALARM_MIN - 1'b1; bg = 10'd250; end
        3: begin al = 10'd300;  bg = BG_MAX + 1'b1;   end
        4: begin al = ALARM_MAX + 1'b1; bg = BG_MIN - 1'b1; end
        default: begin
          al = ALARM_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 19)
                                                      : $urandom_range(601, 1023));
          bg = LVL_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 19)
                                                    : $urandom_range(501, 1023));
        end
      endcase
      run_phase(al, bg, 29, 1'b0);
    end

    // Wait for anything stray to show up before the final check
    repeat (40) @(posedge clk);
    if (mismatches == 0 && reading_fifo.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: end the run if the block hangs
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sbt_pkg.sv
rtl/smoke_background_tracker.sv
dv/tb_smoke_background_tracker.sv
